>>> src/normal_cdf_poly_approx_macros.svh
// assertion macros shared by the checker
`ifndef NORMAL_CDF_POLY_APPROX_MACROS_SVH
`define NORMAL_CDF_POLY_APPROX_MACROS_SVH

// property checked on every clock edge outside reset
`define NCDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define NCDF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/ncdf_pkg.sv
`default_nettype none
package ncdf_pkg;

    localparam int IN_W  = 17;
    localparam int OUT_W = 17;
    localparam int MAG_W = 15;
    localparam int Y_W   = 30;
    localparam int ACC_W = 32;
    localparam int HORNER_N = 6;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS = 4;
    localparam int SQ_N = 4;

    localparam logic signed [IN_W-1:0] LIMIT_POS = 17'sd20480;
    localparam logic signed [IN_W-1:0] LIMIT_NEG = -17'sd20480;
    localparam logic [31:0] INV_SQRT2 = 32'd3037000500;
    localparam logic [OUT_W-1:0] PROB_ONE  = 17'd65536;
    localparam logic [OUT_W-1:0] PROB_HALF = 17'd32768;
    localparam logic [ACC_W-1:0] ONE_Q28 = 32'h1000_0000;
    localparam logic [ACC_W-1:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [ACC_W-1:0] C6 = 32'd11560;

    // addend of each horner step, the last one adds the leading one
    localparam logic [ACC_W-1:0] HORNER_ADD [HORNER_N] = '{
        32'd74240, 32'd40806, 32'd2488538, 32'd11349991, 32'd18930895, ONE_Q28
    };

    // flags that travel with every item
    typedef struct packed {
        logic valid;
        logic neg;
        logic lo;
        logic hi;
    } t_side;

    // one restoring-division slice of DIV_BITS quotient bits
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
    } t_div;

    function automatic t_div div_slice(t_div v, logic [31:0] d);
        t_div w;
        logic [31:0] t;
        w = v;
        for (int k = 0; k < DIV_BITS; k++) begin
            t = {w.rem[30:0], w.num[31]};
            w.num = {w.num[30:0], 1'b0};
            if (t >= d) begin
                w.rem = t - d;
                w.quo = {w.quo[30:0], 1'b1};
            end else begin
                w.rem = t;
                w.quo = {w.quo[30:0], 1'b0};
            end
        end
        return w;
    endfunction

endpackage
`default_nettype wire

>>> src/normal_cdf_poly_approx.sv
// normal_cdf_poly_approx: cumulative standard normal probability
// input channel: i_valid, i_abscissa (signed Q5.12), o_stall
// output channel: o_valid, o_probability (unsigned Q1.16, 65536 = 1.0), i_stall
// a transfer happens on a rising edge with valid high and stall low
// from input transfer to o_valid an item passes the input register,
// one scaling multiply, six horner stages, an eight-stage reciprocal
// (four quotient bits per stage), four squaring stages and the output register
// throughput is one item per cycle unless the output stalls; every stage holds one item
// inputs below -5.0 give 0 and above +5.0 give 65536
// when the output is valid and i_stall is high the whole pipeline holds,
// o_stall is raised and the waiting result stays unchanged
// synchronous active-low reset empties the pipeline; the datapath registers are not reset
`default_nettype none
module normal_cdf_poly_approx (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic signed [ncdf_pkg::IN_W-1:0] i_abscissa,
    output logic                             o_stall,
    output logic                             o_valid,
    output logic [ncdf_pkg::OUT_W-1:0]       o_probability,
    input  wire logic                        i_stall
);
    import ncdf_pkg::*;

    logic w_adv;
    logic [IN_W-1:0] w_mag;

    t_side            r_s0;
    logic [MAG_W-1:0] r_mag;
    t_side            r_s1;
    logic [Y_W-1:0]   r_y;
    t_side            r_hs [HORNER_N];
    logic [Y_W-1:0]   r_hy [HORNER_N];
    logic [ACC_W-1:0] r_ha [HORNER_N];
    logic [ACC_W-1:0] n_ha [HORNER_N];
    t_side            w_ds;
    logic [31:0]      w_dq;
    t_side            r_qs [SQ_N];
    logic [31:0]      r_qr [SQ_N];
    logic [31:0]      n_qr [SQ_N];
    logic [47:0]      w_yprod;
    logic [31:0]      w_erf;
    logic [32:0]      w_half_sum;
    logic [OUT_W-1:0] w_half;
    logic [OUT_W-1:0] n_prob;
    logic             r_valid;
    logic [OUT_W-1:0] r_prob;

    // pipeline advances unless a result waits on a stalled receiver
    assign w_adv   = !(r_valid && i_stall);
    assign o_stall = !w_adv;

    assign w_mag = i_abscissa[IN_W-1] ? IN_W'(-i_abscissa) : IN_W'(i_abscissa);

    // y = |u| / sqrt2 in Q28
    assign w_yprod = {33'd0, r_mag} * {16'd0, INV_SQRT2} + 48'd32768;

    // horner steps
    always_comb begin
        logic [63:0] p;
        for (int k = 0; k < HORNER_N; k++) begin
            if (k == 0) p = {34'd0, r_y} * {32'd0, C6} + 64'h800_0000;
            else        p = {34'd0, r_hy[k-1]} * {32'd0, r_ha[k-1]} + 64'h800_0000;
            n_ha[k] = HORNER_ADD[k] + p[59:28];
        end
    end

    // four squarings give s^-16
    always_comb begin
        logic [63:0] q;
        for (int k = 0; k < SQ_N; k++) begin
            if (k == 0) q = {32'd0, w_dq} * {32'd0, w_dq} + 64'h4000_0000;
            else        q = {32'd0, r_qr[k-1]} * {32'd0, r_qr[k-1]} + 64'h4000_0000;
            n_qr[k] = q[62:31];
        end
    end

    // erf and final probability
    assign w_erf      = ONE_Q31 - r_qr[SQ_N-1];
    assign w_half_sum = {1'b0, w_erf} + 33'd32768;
    assign w_half     = w_half_sum[32:16];
    always_comb begin
        if (r_qs[SQ_N-1].lo)       n_prob = '0;
        else if (r_qs[SQ_N-1].hi)  n_prob = PROB_ONE;
        else if (r_qs[SQ_N-1].neg) n_prob = PROB_HALF - w_half;
        else                       n_prob = PROB_HALF + w_half;
    end

    // control: valid and range flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            for (int k = 0; k < HORNER_N; k++) r_hs[k] <= '0;
            for (int k = 0; k < SQ_N; k++) r_qs[k] <= '0;
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0.valid <= i_valid;
            r_s0.neg   <= i_abscissa[IN_W-1];
            r_s0.lo    <= i_abscissa < LIMIT_NEG;
            r_s0.hi    <= i_abscissa > LIMIT_POS;
            r_s1 <= r_s0;
            r_hs[0] <= r_s1;
            for (int k = 1; k < HORNER_N; k++) r_hs[k] <= r_hs[k-1];
            r_qs[0] <= w_ds;
            for (int k = 1; k < SQ_N; k++) r_qs[k] <= r_qs[k-1];
            r_valid <= r_qs[SQ_N-1].valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mag <= w_mag[MAG_W-1:0];
            r_y   <= w_yprod[45:16];
            r_hy[0] <= r_y;
            for (int k = 1; k < HORNER_N; k++) r_hy[k] <= r_hy[k-1];
            for (int k = 0; k < HORNER_N; k++) r_ha[k] <= n_ha[k];
            for (int k = 0; k < SQ_N; k++) r_qr[k] <= n_qr[k];
            r_prob <= n_prob;
        end
    end

    // reciprocal of s in Q31
    ncdf_recip u_recip (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_side (r_hs[HORNER_N-1]),
        .i_den  (r_ha[HORNER_N-1]),
        .o_side (w_ds),
        .o_quo  (w_dq)
    );

    assign o_valid       = r_valid;
    assign o_probability = r_prob;
endmodule
`default_nettype wire

>>> src/ncdf_recip.sv
`default_nettype none
module ncdf_recip (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire ncdf_pkg::t_side i_side,
    input  wire logic [31:0]    i_den,
    output ncdf_pkg::t_side     o_side,
    output logic [31:0]         o_quo
);
    import ncdf_pkg::*;

    t_side       r_side [DIV_STAGES];
    t_div        r_div  [DIV_STAGES];
    logic [31:0] r_den  [DIV_STAGES];
    t_div        n_div  [DIV_STAGES];
    t_div        w_init;

    // numerator is 2^59 plus half the divisor; top 28 bits seed the remainder
    always_comb begin
        w_init.rem = {4'd0, 28'h800_0000};
        w_init.num = {1'b0, i_den[31:1]};
        w_init.quo = '0;
        n_div[0] = div_slice(w_init, i_den);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_div[k] = div_slice(r_div[k-1], r_den[k-1]);
        end
    end

    // side flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_side[k] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < DIV_STAGES; k++) r_side[k] <= r_side[k-1];
        end
    end

    // division datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int k = 1; k < DIV_STAGES; k++) r_den[k] <= r_den[k-1];
            for (int k = 0; k < DIV_STAGES; k++) r_div[k] <= n_div[k];
        end
    end

    assign o_side = r_side[DIV_STAGES-1];
    assign o_quo  = r_div[DIV_STAGES-1].quo;
endmodule
`default_nettype wire

>>> src/ncdf_checker.sv
`default_nettype none
`include "normal_cdf_poly_approx_macros.svh"
module ncdf_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic [ncdf_pkg::OUT_W-1:0] o_probability,
    input wire logic                  i_stall
);
    import ncdf_pkg::*;

    // probability never exceeds one
    `NCDF_ASSERT(a_prob_range, o_valid |-> (o_probability <= PROB_ONE), "probability above one")
    // a stalled result holds
    `NCDF_ASSERT(a_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_probability)), "result changed under stall")
    // input stalls only while a result waits
    `NCDF_ASSERT(a_stall_src, o_stall |-> (o_valid && i_stall), "input stalled without output stall")
    // reset empties the pipeline
    `NCDF_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid, "output valid after reset")
endmodule

bind normal_cdf_poly_approx ncdf_checker u_ncdf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .o_probability(o_probability),
    .i_stall      (i_stall)
);
`default_nettype wire

>>> dv/normal_cdf_poly_approx_tb.sv
`default_nettype none
module normal_cdf_poly_approx_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ncdf_pkg::*;

    // expected probabilities, oldest first, and mismatch bookkeeping
    class cdf_scoreboard;
        logic [OUT_W-1:0] prob_q[$];
        int mismatches;
        int unexpected;

        function new();
            mismatches = 0;
            unexpected = 0;
        endfunction

        // rounded q28 product
        function automatic logic [63:0] mul28(logic [63:0] a, logic [63:0] b);
            return (a * b + 64'd134217728) >> 28;
        endfunction

        // compute the cdf of one abscissa
        function automatic logic [OUT_W-1:0] cdf_of(logic signed [IN_W-1:0] u);
            logic [63:0] mag, y, acc, s, r, erf, half;
            if (u < LIMIT_NEG) return '0;
            if (u > LIMIT_POS) return PROB_ONE;
            mag = (u < 0) ? 64'(-int'(u)) : 64'(int'(u));
            y = (mag * 64'd3037000500 + 64'd32768) >> 16;
            acc = 64'd11560;
            acc = 64'd74240 + mul28(y, acc);
            acc = 64'd40806 + mul28(y, acc);
            acc = 64'd2488538 + mul28(y, acc);
            acc = 64'd11349991 + mul28(y, acc);
            acc = 64'd18930895 + mul28(y, acc);
            s = (64'd1 << 28) + mul28(y, acc);
            r = ((64'd1 << 59) + (s >> 1)) / s;
            for (int k = 0; k < 4; k++)
                r = (r * r + (64'd1 << 30)) >> 31;
            erf = (64'd1 << 31) - r;
            half = (erf + 64'd32768) >> 16;
            if (u < 0) return OUT_W'(64'd32768 - half);
            return OUT_W'(64'd32768 + half);
        endfunction

        function void note_input(logic signed [IN_W-1:0] u);
            prob_q.push_back(cdf_of(u));
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (prob_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result probability=%0d", got);
                return;
            end
            want = prob_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("mismatch probability: expected %0d actual %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic signed [IN_W-1:0] i_abscissa = '0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic [OUT_W-1:0] o_probability;

    cdf_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    longint cycle_cnt = 0;

    normal_cdf_poly_approx dut (
        .i_clk, .i_rst_n, .i_valid, .i_abscissa, .o_stall,
        .o_valid, .o_probability, .i_stall
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stall: long hold-off when requested, else random
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_cycles <= 60;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_probability);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("normal_cdf_poly_approx_tb NOT OK");
            $finish;
        end
    end

    // offer one abscissa, hold it until the transfer
    task automatic send_abscissa(logic signed [IN_W-1:0] u);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_abscissa <= u;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(u);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (sb.prob_q.size() != 0) @(posedge i_clk);
    endtask

    // mostly the interesting band, some anywhere in the field
    function automatic logic signed [IN_W-1:0] rand_abscissa();
        case ($urandom_range(9)) inside
            0, 1: return IN_W'($urandom);
            2: return IN_W'(int'($urandom_range(20490, 20470)) *
                             ($urandom_range(1) ? 1 : -1));
            default: return IN_W'(int'($urandom_range(40960)) - 20480);
        endcase
    endfunction

    initial begin
        logic signed [IN_W-1:0] directed[$];
        directed = {17'sh10000, 17'shFFFF, -17'sd20481, -17'sd20480, -17'sd20479,
                    17'sd20479, 17'sd20480, 17'sd20481, 17'sd0, 17'sd1, -17'sd1,
                    17'sd4096, -17'sd4096, 17'sd8192, -17'sd8192, 17'sd12288,
                    -17'sd12288, 17'sh15555, 17'sh0AAAA, 17'sd2048};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_abscissa(directed[k]);
        drain();

        // sender rarely idles, receiver mostly stalls
        send_idle_pct = 9;
        recv_idle_pct = 75;
        repeat (400) send_abscissa(rand_abscissa());

        // long receiver hold-off while items keep coming
        hold_reqs++;
        repeat (80) send_abscissa(rand_abscissa());
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 9;
        repeat (400) send_abscissa(rand_abscissa());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (420) send_abscissa(rand_abscissa());
        drain();
        repeat (30) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.prob_q.size() == 0)
            $display("normal_cdf_poly_approx_tb OK");
        else
            $display("normal_cdf_poly_approx_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
